FILE: rtl/core/multi_species_life_cell_step_macros.svh
// assertion macros for the multi-species life cell step block
`ifndef MULTI_SPECIES_LIFE_CELL_STEP_MACROS_SVH
`define MULTI_SPECIES_LIFE_CELL_STEP_MACROS_SVH
`ifndef SYNTHESIS
`define MSL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MSL_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MSL_ASSERT(label, clk, rst_n, prop, msg)
`define MSL_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

FILE: rtl/core/msl_pkg.sv
// package of the multi-species life cell step block
package msl_pkg;
    localparam int GRID_COLS_DEF = 64;
    localparam int GRID_ROWS_DEF = 64;
    localparam logic [15:0] P_ONE = 16'hFFFF;
    localparam logic [15:0] DECAY_RESET = 16'd65208;
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVOLVE = 1'b1;
    localparam logic [1:0] SP_NORMAL = 2'd0;
    localparam logic [1:0] SP_STRONG = 2'd1;
    localparam logic [1:0] SP_FAST = 2'd2;
    localparam logic [1:0] SP_BAD = 2'd3;

    typedef struct packed {
        logic        func;
        logic [7:0]  cell_x;
        logic [7:0]  cell_y;
        logic        load_live;
        logic [1:0]  load_type;
        logic [15:0] random_fraction;
        logic        coin;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_x;
        logic [7:0] out_y;
        logic       out_live;
        logic [1:0] out_type;
        logic       generation_done;
    } t_out_item;

    typedef struct packed {
        logic        live;
        logic [1:0]  kind;
        logic [15:0] prob;
    } t_cell;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_LAST, ST_CALC, ST_DECAY, ST_OUT
    } t_state;
endpackage

FILE: rtl/core/msl_stream_if.sv
// valid/ready channel interfaces of the block
interface msl_in_if;
    logic valid;
    logic ready;
    msl_pkg::t_in_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface msl_out_if;
    logic valid;
    logic ready;
    msl_pkg::t_out_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface msl_cfg_if;
    logic valid;
    logic ready;
    logic [15:0] data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/core/multi_species_life_cell_step.sv
// top level of the multi-species life cell step block
// A load item goes from its accept straight to the cell write, done only for a target
// inside the grid, and the result register load. On an evolve the current cell
// and its eight wrapped neighbors are read one a cycle through the single read port
// of the cell memory. Then come a state to capture the cell, a rule step
// and one registered decay multiply, and then the next-grid write with the result
// register load. One item is in work at a time. The result sits in an output register,
// and the next item is taken in the cycle after that result is handed over. A stalled
// result sink adds its stall cycles. The cell memory holds both grids and has no reset;
// the user must evolve only cells that were loaded, which the block does not enforce.
`include "multi_species_life_cell_step_macros.svh"
module multi_species_life_cell_step #(
    parameter int GRID_COLS = msl_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS = msl_pkg::GRID_ROWS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    msl_cfg_if.sink   i_cfg,
    msl_in_if.sink    i_in,
    msl_out_if.source o_out
);
    import msl_pkg::*;

    localparam int CELLS = GRID_COLS * GRID_ROWS;
    localparam int CW = $clog2(GRID_COLS);
    localparam int RW = $clog2(GRID_ROWS);
    localparam int AW = $clog2(CELLS) + 1;

    // both grids in one memory, buffer select is the top address bit
    t_cell mem [0:2*CELLS-1];

    t_state r_state, n_state;
    logic [15:0] r_decay;
    logic        r_sel;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    t_in_item    r_item;
    logic [3:0]  r_tap;
    logic [3:0]  r_cnt;
    logic [3:0]  r_tc0, r_tc1, r_tc2;
    t_cell       r_me;
    t_cell       r_new;
    t_cell       r_rd;
    logic        r_rd_nb;
    logic        r_mut_dec;
    logic [31:0] r_prod;
    logic        r_ovld;
    t_out_item   r_out;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_cell         wr_data;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready = (r_state == ST_IDLE) && !r_ovld;
    assign o_out.valid = r_ovld;
    assign o_out.data = r_out;

    wire in_acc = i_in.valid && i_in.ready;

    // neighbor tap order: 0..7 neighbors, 8 the cell itself
    logic [1:0] tdx, tdy;
    logic [CW-1:0] tx;
    logic [RW-1:0] ty;
    always_comb begin
        case (r_tap)
            4'd0: begin tdx = 2'd0; tdy = 2'd0; end
            4'd1: begin tdx = 2'd0; tdy = 2'd1; end
            4'd2: begin tdx = 2'd0; tdy = 2'd2; end
            4'd3: begin tdx = 2'd1; tdy = 2'd0; end
            4'd4: begin tdx = 2'd1; tdy = 2'd2; end
            4'd5: begin tdx = 2'd2; tdy = 2'd0; end
            4'd6: begin tdx = 2'd2; tdy = 2'd1; end
            4'd7: begin tdx = 2'd2; tdy = 2'd2; end
            default: begin tdx = 2'd1; tdy = 2'd1; end
        endcase
        if (tdx == 2'd0) begin
            tx = (r_col == '0) ? CW'(GRID_COLS - 1) : r_col - 1'b1;
        end else if (tdx == 2'd2) begin
            tx = (r_col == CW'(GRID_COLS - 1)) ? '0 : r_col + 1'b1;
        end else begin
            tx = r_col;
        end
        if (tdy == 2'd0) begin
            ty = (r_row == '0) ? RW'(GRID_ROWS - 1) : r_row - 1'b1;
        end else if (tdy == 2'd2) begin
            ty = (r_row == RW'(GRID_ROWS - 1)) ? '0 : r_row + 1'b1;
        end else begin
            ty = r_row;
        end
    end

    function automatic logic [AW-1:0] cell_addr(input logic sel, input logic [CW-1:0] x,
                                                input logic [RW-1:0] y);
        logic [AW:0] a;
        a = (AW+1)'(x) + (AW+1)'(y) * (AW+1)'(GRID_COLS) + (sel ? (AW+1)'(CELLS) : '0);
        return a[AW-1:0];
    endfunction

    assign rd_en = (r_state == ST_READ);
    assign rd_addr = cell_addr(r_sel, tx, ty);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    // load target check
    wire ld_in = (r_item.cell_x < 9'(GRID_COLS)) && (r_item.cell_y < 9'(GRID_ROWS));
    wire [1:0] ld_kind = (r_item.load_type == SP_BAD) ? SP_NORMAL : r_item.load_type;

    // rule step from gathered counts
    logic [3:0] s_lo, s_hi, b_lo, b_hi;
    logic [1:0] me_kind, best;
    t_cell      calc;
    logic       calc_dec;
    always_comb begin
        me_kind = (r_me.kind == SP_BAD) ? SP_NORMAL : r_me.kind;
        unique case (me_kind)
            SP_STRONG: begin s_lo = 4'd3; s_hi = 4'd4; b_lo = 4'd1; b_hi = 4'd2; end
            SP_FAST:   begin s_lo = 4'd2; s_hi = 4'd3; b_lo = 4'd2; b_hi = 4'd3; end
            default:   begin s_lo = 4'd2; s_hi = 4'd3; b_lo = 4'd3; b_hi = 4'd3; end
        endcase
        best = SP_NORMAL;
        if (r_tc1 > r_tc0) best = SP_STRONG;
        if (r_tc2 > ((r_tc1 > r_tc0) ? r_tc1 : r_tc0)) best = SP_FAST;
        calc = '{live: r_me.live, kind: me_kind, prob: r_me.prob};
        calc_dec = 1'b0;
        if (!r_me.live) begin
            if (r_cnt >= b_lo && r_cnt <= b_hi) begin
                calc = '{live: 1'b1, kind: best, prob: P_ONE};
            end
        end else if (r_cnt > s_hi || r_cnt < s_lo) begin
            calc.live = 1'b0;
        end else begin
            calc_dec = 1'b1;
            if (me_kind == SP_NORMAL && r_item.random_fraction > r_me.prob) begin
                calc.kind = r_item.coin ? SP_STRONG : SP_FAST;
                calc.prob = P_ONE;
            end
        end
    end

    wire last_row = (r_row == RW'(GRID_ROWS - 1));
    wire last_col = (r_col == CW'(GRID_COLS - 1));

    always_comb begin
        n_state = r_state;
        wr_en = 1'b0;
        wr_addr = cell_addr(r_sel, r_item.cell_x[CW-1:0], r_item.cell_y[RW-1:0]);
        wr_data = '{live: r_item.load_live, kind: ld_kind, prob: P_ONE};
        unique case (r_state)
            ST_IDLE: if (in_acc) n_state = i_in.data.func ? ST_READ : ST_OUT;
            ST_READ: if (r_tap == 4'd8) n_state = ST_LAST;
            ST_LAST: n_state = ST_CALC;
            ST_CALC: n_state = ST_DECAY;
            ST_DECAY: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                n_state = ST_IDLE;
                if (r_item.func == FUNC_LOAD) begin
                    wr_en = ld_in;
                end else begin
                    wr_en = 1'b1;
                    wr_addr = cell_addr(!r_sel, r_col, r_row);
                    wr_data = r_new;
                    if (r_mut_dec) begin
                        wr_data.prob = (r_new.prob == P_ONE) ? r_decay : r_prod[31:16];
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_decay <= DECAY_RESET;
            r_sel <= 1'b0;
            r_col <= '0;
            r_row <= '0;
            r_ovld <= 1'b0;
            r_tap <= '0;
            r_rd_nb <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) r_decay <= i_cfg.data;
            if (o_out.valid && o_out.ready) r_ovld <= 1'b0;
            r_rd_nb <= rd_en && (r_tap != 4'd8);
            if (r_state == ST_READ) r_tap <= r_tap + 1'b1;
            else r_tap <= '0;
            if (r_state == ST_OUT) begin
                r_ovld <= 1'b1;
                if (r_item.func == FUNC_EVOLVE) begin
                    if (last_row) begin
                        r_row <= '0;
                        if (last_col) begin
                            r_col <= '0;
                            r_sel <= !r_sel;
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                    end else begin
                        r_row <= r_row + 1'b1;
                    end
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= i_in.data;
            r_cnt <= '0;
            r_tc0 <= '0;
            r_tc1 <= '0;
            r_tc2 <= '0;
        end
        if (r_rd_nb && r_rd.live) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_rd.kind == SP_NORMAL) r_tc0 <= r_tc0 + 1'b1;
            if (r_rd.kind == SP_STRONG) r_tc1 <= r_tc1 + 1'b1;
            if (r_rd.kind == SP_FAST) r_tc2 <= r_tc2 + 1'b1;
        end
        if (r_state == ST_LAST) r_me <= r_rd;
        if (r_state == ST_CALC) begin
            r_new <= calc;
            r_mut_dec <= calc_dec;
        end
        if (r_state == ST_DECAY) r_prod <= 32'(r_new.prob) * 32'(r_decay);
        if (r_state == ST_OUT) begin
            if (r_item.func == FUNC_LOAD) begin
                r_out <= '{out_x: r_item.cell_x, out_y: r_item.cell_y,
                           out_live: ld_in & r_item.load_live,
                           out_type: ld_in ? ld_kind : SP_NORMAL, generation_done: 1'b0};
            end else begin
                r_out <= '{out_x: 8'(r_col), out_y: 8'(r_row), out_live: r_new.live,
                           out_type: r_new.kind, generation_done: last_row && last_col};
            end
        end
    end

    `MSL_ASSERT(a_no_accept_busy, i_clk, i_rst_n, (r_state != ST_IDLE) |-> !i_in.ready,
                "item accepted while busy")
    `MSL_ASSERT(a_out_after_work, i_clk, i_rst_n, $rose(r_ovld) |-> $past(r_state == ST_OUT),
                "result without work")
    `MSL_ASSERT(a_counts_sum, i_clk, i_rst_n,
                (r_state == ST_CALC) |-> (r_cnt == r_tc0 + r_tc1 + r_tc2),
                "species counts do not add up")
endmodule

FILE: tb/sv/life_step_checker.sv
// checker of the multi-species life cell step block: predicts and compares results
`timescale 1ns / 100ps
module life_step_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    msl_cfg_if   i_cfg_mon,
    msl_in_if    i_in_mon,
    msl_out_if   i_out_mon,
    output int   o_fail_count,
    output int   o_pending
);
    import msl_pkg::*;

    localparam int COLS  = GRID_COLS_DEF;
    localparam int ROWS  = GRID_ROWS_DEF;
    localparam int CELLS = COLS * ROWS;

    t_cell       life_grid [0:2*CELLS-1];
    logic        cur_sel;
    int          scan_c;
    int          scan_r;
    logic [15:0] decay_val;
    t_out_item   cell_result_q [$];
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = cell_result_q.size();

    function automatic logic [15:0] decayed(input logic [15:0] p);
        if (p == P_ONE) return decay_val;
        return 16'((32'(p) * 32'(decay_val)) >> 16);
    endfunction

    // advances the predicted grid by one item and returns its result
    function automatic t_out_item next_cell_result(input t_in_item it);
        t_out_item r;
        t_cell     me;
        logic [1:0] kind;
        int        cnt, tx, ty, best, bestn, base;
        int        tc [3];
        int        s_lo, s_hi, b_lo, b_hi;
        r = '0;
        if (it.func == FUNC_LOAD) begin
            kind = (it.load_type == SP_BAD) ? SP_NORMAL : it.load_type;
            r.out_x = it.cell_x;
            r.out_y = it.cell_y;
            if (it.cell_x < COLS && it.cell_y < ROWS) begin
                base = cur_sel ? CELLS : 0;
                life_grid[base + it.cell_x + it.cell_y * COLS] = '{it.load_live, kind, P_ONE};
                r.out_live = it.load_live;
                r.out_type = kind;
            end
            return r;
        end
        base = cur_sel ? CELLS : 0;
        cnt = 0;
        tc[0] = 0; tc[1] = 0; tc[2] = 0;
        for (int dx = -1; dx <= 1; dx++) begin
            tx = (scan_c + COLS + dx) % COLS;
            for (int dy = -1; dy <= 1; dy++) begin
                if (dx != 0 || dy != 0) begin
                    ty = (scan_r + ROWS + dy) % ROWS;
                    me = life_grid[base + tx + ty * COLS];
                    if (me.live) begin
                        cnt++;
                        if (me.kind != SP_BAD) tc[me.kind]++;
                    end
                end
            end
        end
        best = 0;
        bestn = 0;
        for (int i = 0; i < 3; i++) begin
            if (tc[i] > bestn) begin
                bestn = tc[i];
                best = i;
            end
        end
        me = life_grid[base + scan_c + scan_r * COLS];
        if (me.kind == SP_BAD) me.kind = SP_NORMAL;
        case (me.kind)
            SP_STRONG: begin s_lo = 3; s_hi = 4; b_lo = 1; b_hi = 2; end
            SP_FAST:   begin s_lo = 2; s_hi = 3; b_lo = 2; b_hi = 3; end
            default:   begin s_lo = 2; s_hi = 3; b_lo = 3; b_hi = 3; end
        endcase
        if (!me.live) begin
            if (cnt >= b_lo && cnt <= b_hi) begin
                me.live = 1'b1;
                me.kind = 2'(best);
                me.prob = P_ONE;
            end
        end else if (cnt > s_hi || cnt < s_lo) begin
            me.live = 1'b0;
        end else begin
            // surviving normal cell may mutate
            if (me.kind == SP_NORMAL && it.random_fraction > me.prob) begin
                me.kind = it.coin ? SP_STRONG : SP_FAST;
                me.prob = P_ONE;
            end
            me.prob = decayed(me.prob);
        end
        life_grid[(cur_sel ? 0 : CELLS) + scan_c + scan_r * COLS] = me;
        r.out_x = 8'(scan_c);
        r.out_y = 8'(scan_r);
        r.out_live = me.live;
        r.out_type = me.kind;
        if (scan_r + 1 >= ROWS) begin
            scan_r = 0;
            if (scan_c + 1 >= COLS) begin
                scan_c = 0;
                cur_sel = ~cur_sel;
                r.generation_done = 1'b1;
            end else begin
                scan_c++;
            end
        end else begin
            scan_r++;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item exp_r;
        t_out_item got;
        if (!i_rst_n) begin
            cur_sel = 1'b0;
            scan_c = 0;
            scan_r = 0;
            decay_val = DECAY_RESET;
            fails = 0;
            cell_result_q.delete();
        end else begin
            if (i_cfg_mon.valid && i_cfg_mon.ready) decay_val = i_cfg_mon.data;
            if (i_out_mon.valid && i_out_mon.ready) begin
                got = i_out_mon.data;
                if (cell_result_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    fails++;
                end else begin
                    exp_r = cell_result_q.pop_front();
                    if (got.out_x != exp_r.out_x) begin
                        $display("%0t: out_x exp %0d got %0d", $time, exp_r.out_x, got.out_x);
                        fails++;
                    end
                    if (got.out_y != exp_r.out_y) begin
                        $display("%0t: out_y exp %0d got %0d", $time, exp_r.out_y, got.out_y);
                        fails++;
                    end
                    if (got.out_live != exp_r.out_live) begin
                        $display("%0t: out_live exp %0d got %0d", $time,
                                 exp_r.out_live, got.out_live);
                        fails++;
                    end
                    if (got.out_type != exp_r.out_type) begin
                        $display("%0t: out_type exp %0d got %0d", $time,
                                 exp_r.out_type, got.out_type);
                        fails++;
                    end
                    if (got.generation_done != exp_r.generation_done) begin
                        $display("%0t: generation_done exp %0d got %0d", $time,
                                 exp_r.generation_done, got.generation_done);
                        fails++;
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready)
                cell_result_q.push_back(next_cell_result(i_in_mon.data));
        end
    end
endmodule

FILE: tb/sv/tb_top.sv
// testbench top of the multi-species life cell step block: stimulus and verdict
`timescale 1ns / 100ps
module tb_top;
    import msl_pkg::*;

    localparam int COLS        = GRID_COLS_DEF;
    localparam int ROWS        = GRID_ROWS_DEF;
    localparam int EVO_COLS    = 8;
    localparam int CYCLE_LIMIT = 2000000;

    logic i_clk;
    logic i_rst_n;
    logic quiet;         // no idling on either side
    int   sent_cnt;
    int   recv_cnt;
    int   cycles;
    int   stall_left;
    int   fail_count;
    int   pending;

    msl_cfg_if cfg_if ();
    msl_in_if  in_if ();
    msl_out_if out_if ();

    multi_species_life_cell_step u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    life_step_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_mon    (cfg_if),
        .i_in_mon     (in_if),
        .i_out_mon    (out_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // result sink with random stall bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            stall_left <= 0;
            recv_cnt <= 0;
        end else begin
            if (out_if.valid && out_if.ready) recv_cnt <= recv_cnt + 1;
            if (stall_left > 0) begin
                out_if.ready <= 1'b0;
                stall_left <= stall_left - 1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                out_if.ready <= 1'b0;
                stall_left <= $urandom_range(0, 10);
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // one item through the input channel, valid held across back-to-back items
    task automatic send_item(input t_in_item it);
        int gap;
        gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 11) : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data <= it;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sent_cnt++;
    endtask

    task automatic load_cell(input int x, input int y, input logic live, input logic [1:0] kind);
        t_in_item it;
        it = '0;
        it.func = FUNC_LOAD;
        it.cell_x = 8'(x);
        it.cell_y = 8'(y);
        it.load_live = live;
        it.load_type = kind;
        it.random_fraction = 16'($urandom);
        it.coin = 1'($urandom);
        send_item(it);
    endtask

    task automatic evolve_cell();
        t_in_item it;
        it = '0;
        it.func = FUNC_EVOLVE;
        it.cell_x = 8'($urandom);
        it.cell_y = 8'($urandom);
        it.load_live = 1'($urandom);
        it.load_type = 2'($urandom);
        // extremes of the mutation draw are common
        case ($urandom_range(0, 3))
            0: it.random_fraction = P_ONE;
            1: it.random_fraction = 16'd0;
            default: it.random_fraction = 16'($urandom);
        endcase
        it.coin = 1'($urandom);
        send_item(it);
    endtask

    // waits until every result is in, then lets the block settle
    task automatic wait_idle();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (recv_cnt != sent_cnt) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_decay(input logic [15:0] v);
        cfg_if.valid <= 1'b1;
        cfg_if.data <= v;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // evolve n cells, with random loads mixed in (some outside the grid)
    task automatic run_evolves(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                if ($urandom_range(0, 3) == 0)
                    load_cell($urandom_range(0, 255), $urandom_range(0, 255),
                              1'($urandom), 2'($urandom));
                else
                    load_cell($urandom_range(0, COLS - 1), $urandom_range(0, ROWS - 1),
                              1'($urandom), 2'($urandom));
            end
            evolve_cell();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        quiet = 1'b0;
        sent_cnt = 0;
        cycles = 0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        in_if.valid = 1'b0;
        in_if.data = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed loads: out of grid, bad species code, grid corners
        load_cell(255, 255, 1'b1, SP_FAST);
        load_cell(COLS, 0, 1'b1, SP_STRONG);
        load_cell(0, ROWS, 1'b1, SP_NORMAL);
        load_cell(200, 17, 1'b1, SP_BAD);
        load_cell(0, 0, 1'b1, SP_BAD);
        load_cell(COLS - 1, ROWS - 1, 1'b1, SP_FAST);
        load_cell(COLS - 1, 0, 1'b0, SP_STRONG);
        load_cell(0, ROWS - 1, 1'b1, SP_NORMAL);

        // fill every column that the partial scan reads, last column included
        for (int i = 0; i < EVO_COLS + 2; i++)
            for (int y = 0; y < ROWS; y++)
                load_cell((i + COLS - 1) % COLS, y, ($urandom_range(0, 9) < 4), 2'($urandom));

        // decay zero: survivors drop to p = 0 at once
        wait_idle();
        write_decay(16'd0);
        run_evolves(160);

        // decay factor at full scale, p barely moves
        wait_idle();
        write_decay(16'hFFFF);
        run_evolves(160);

        // default-like and random decay, ending without idling
        wait_idle();
        write_decay(DECAY_RESET);
        run_evolves(80);
        wait_idle();
        write_decay(16'($urandom));
        run_evolves(60);
        quiet <= 1'b1;
        run_evolves(EVO_COLS * ROWS - 460);

        wait_idle();
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
